>>> rtl/core/cop_pkg.sv
// Shared types and constants for the collider overlap test.
`default_nettype none
package cop_pkg;

   // Collider kinds, as carried in the kind flag of a transaction.
   localparam logic KIND_RECT   = 1'b0;
   localparam logic KIND_CIRCLE = 1'b1;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SELF_TYPE   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SELF_X      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SELF_Y      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SELF_WIDTH  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SELF_HEIGHT = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SELF_RADIUS = 3'd5;

   // Result channel data width: one flag padded to a byte.
   localparam int unsigned RSP_DATA_BITS = 8;

   // Which pair test applies to a collider.
   typedef enum logic [1:0] {
      MODE_RECT_RECT,
      MODE_CIRC_CIRC,
      MODE_CIRC_RECT
   } pair_mode_type;

   // Control that travels with a collider down the pipeline.
   typedef struct packed {
      logic          last;
      logic          skip;
      pair_mode_type mode;
      logic          rect_hit;
   } ctl_type;

endpackage
`default_nettype wire

>>> rtl/core/collider_overlap_test.sv
// Top level of the collider overlap test: query registers, pipeline and result register.
//
// Tests one query collider (rectangle or circle, held in the csr_ registers)
// against a stream of other colliders arriving on the req_ channel, and
// returns one hit flag on the rsp_ channel for each run ended by req_tlast.
// Colliders flagged as the query itself contribute no hit, but a last one
// still ends the run and produces a result.
//
// Pipeline: input register, gap stage, square stage, then compare and
// accumulate into the result register. A transaction enters every cycle
// unless the pipeline holds; the result of a run is registered once its last
// transaction has passed the input, gap and square registers. The square
// stage has three multipliers, one for each square.
//
// Reset clears the valid bits, the running hit flag and the query registers.
// When the receiver stalls, colliders that are not last keep flowing; the
// pipeline holds only once a last collider reaches the compare stage while
// the previous result still waits, and req_tready drops until rsp_tready.
// Write the query registers only while no run is in progress.
`default_nettype none
module collider_overlap_test #(
   parameter int unsigned COORD_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Request channel.
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // tdata: other_x, other_y, other_width, other_height, other_radius, zero pad
   input  wire logic [((5*COORD_BITS-3+7)/8)*8-1:0]  req_tdata,
   // tuser: other_type, is_self
   input  wire logic [1:0]                           req_tuser,
   input  wire logic                                 req_tlast,
   // Response channel.
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // tdata: colliding, zero pad
   output logic [cop_pkg::RSP_DATA_BITS-1:0]         rsp_tdata,
   // Configuration write port.
   input  wire logic                                 csr_we,
   input  wire logic [cop_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [COORD_BITS-1:0]                csr_wdata
);

   localparam int unsigned W     = COORD_BITS;
   localparam int unsigned OFF_Y = W;
   localparam int unsigned OFF_W = 2*W;
   localparam int unsigned OFF_H = 3*W - 1;
   localparam int unsigned OFF_R = 4*W - 2;

   // Query collider registers.
   logic                self_kind_ff;
   logic signed [W-1:0] self_x_ff, self_y_ff;
   logic        [W-2:0] self_width_ff, self_height_ff, self_radius_ff;

   // Input register.
   logic                s0_valid_ff, s0_last_ff, s0_skip_ff, s0_kind_ff;
   logic signed [W-1:0] s0_x_ff, s0_y_ff;
   logic        [W-2:0] s0_width_ff, s0_height_ff, s0_radius_ff;

   // Stage links.
   logic                s1_valid, s2_valid;
   cop_pkg::ctl_type    s1_ctl, s2_ctl;
   logic        [W+1:0] s1_gap_x, s1_gap_y;
   logic        [W-1:0] s1_reach;
   logic      [2*W+3:0] s2_sq_x, s2_sq_y;
   logic      [2*W-1:0] s2_sq_r;

   // Compare and result.
   logic      [2*W+4:0] dist_sum;
   logic                circle_hit, hit;
   logic                advance;
   logic                hit_so_far_ff, hit_so_far_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                colliding_ff, colliding_in;

   // Query registers: drop writes beyond the list.
   always_ff @(posedge clock) begin
      if (reset) begin
         self_kind_ff   <= cop_pkg::KIND_RECT;
         self_x_ff      <= '0;
         self_y_ff      <= '0;
         self_width_ff  <= '0;
         self_height_ff <= '0;
         self_radius_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            cop_pkg::CSR_SELF_TYPE:   self_kind_ff   <= csr_wdata[0];
            cop_pkg::CSR_SELF_X:      self_x_ff      <= csr_wdata;
            cop_pkg::CSR_SELF_Y:      self_y_ff      <= csr_wdata;
            cop_pkg::CSR_SELF_WIDTH:  self_width_ff  <= csr_wdata[W-2:0];
            cop_pkg::CSR_SELF_HEIGHT: self_height_ff <= csr_wdata[W-2:0];
            cop_pkg::CSR_SELF_RADIUS: self_radius_ff <= csr_wdata[W-2:0];
            default: begin
            end
         endcase
      end
   end

   // Hold the whole pipeline only when a finished run cannot reach the result register.
   assign advance    = !(s2_valid && s2_ctl.last && rsp_valid_ff && !rsp_tready);
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_last_ff   <= req_tlast;
         s0_skip_ff   <= req_tuser[1];
         s0_kind_ff   <= req_tuser[0];
         s0_x_ff      <= req_tdata[W-1:0];
         s0_y_ff      <= req_tdata[OFF_Y +: W];
         s0_width_ff  <= req_tdata[OFF_W +: W-1];
         s0_height_ff <= req_tdata[OFF_H +: W-1];
         s0_radius_ff <= req_tdata[OFF_R +: W-1];
      end
   end

   cop_gap #(
      .COORD_BITS(COORD_BITS)
   ) u_gap (
      .clock        (clock),
      .reset        (reset),
      .en           (advance),
      .valid_in     (s0_valid_ff),
      .last_in      (s0_last_ff),
      .skip_in      (s0_skip_ff),
      .self_kind    (self_kind_ff),
      .self_x       (self_x_ff),
      .self_y       (self_y_ff),
      .self_width   (self_width_ff),
      .self_height  (self_height_ff),
      .self_radius  (self_radius_ff),
      .other_kind   (s0_kind_ff),
      .other_x      (s0_x_ff),
      .other_y      (s0_y_ff),
      .other_width  (s0_width_ff),
      .other_height (s0_height_ff),
      .other_radius (s0_radius_ff),
      .valid_out    (s1_valid),
      .ctl_out      (s1_ctl),
      .gap_x_out    (s1_gap_x),
      .gap_y_out    (s1_gap_y),
      .reach_out    (s1_reach)
   );

   cop_square #(
      .COORD_BITS(COORD_BITS)
   ) u_square (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .valid_in  (s1_valid),
      .ctl_in    (s1_ctl),
      .gap_x     (s1_gap_x),
      .gap_y     (s1_gap_y),
      .reach     (s1_reach),
      .valid_out (s2_valid),
      .ctl_out   (s2_ctl),
      .sq_x_out  (s2_sq_x),
      .sq_y_out  (s2_sq_y),
      .sq_r_out  (s2_sq_r)
   );

   // Compare squared distance against squared reach (a rectangle pair takes the overlap flag), then fold into the run.
   always_comb begin
      dist_sum   = {1'b0, s2_sq_x} + {1'b0, s2_sq_y};
      circle_hit = dist_sum <= {5'b00000, s2_sq_r};
      if (s2_ctl.skip) begin
         hit = 1'b0;
      end else if (s2_ctl.mode == cop_pkg::MODE_RECT_RECT) begin
         hit = s2_ctl.rect_hit;
      end else begin
         hit = circle_hit;
      end

      hit_so_far_in = hit_so_far_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      colliding_in  = colliding_ff;
      if (advance && s2_valid) begin
         if (s2_ctl.last) begin
            hit_so_far_in = 1'b0;
            rsp_valid_in  = 1'b1;
            colliding_in  = hit_so_far_ff || hit;
         end else begin
            hit_so_far_in = hit_so_far_ff || hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_so_far_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hit_so_far_ff <= hit_so_far_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      colliding_ff <= colliding_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(cop_pkg::RSP_DATA_BITS-1){1'b0}}, colliding_ff};

endmodule
`default_nettype wire

>>> rtl/core/cop_gap.sv
// Gap stage: per-axis gaps, reach and the rectangle overlap flag, registered.
`default_nettype none
module cop_gap #(
   parameter int unsigned COORD_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         en,
   input  wire logic                         valid_in,
   input  wire logic                         last_in,
   input  wire logic                         skip_in,
   input  wire logic                         self_kind,
   input  wire logic signed [COORD_BITS-1:0] self_x,
   input  wire logic signed [COORD_BITS-1:0] self_y,
   input  wire logic        [COORD_BITS-2:0] self_width,
   input  wire logic        [COORD_BITS-2:0] self_height,
   input  wire logic        [COORD_BITS-2:0] self_radius,
   input  wire logic                         other_kind,
   input  wire logic signed [COORD_BITS-1:0] other_x,
   input  wire logic signed [COORD_BITS-1:0] other_y,
   input  wire logic        [COORD_BITS-2:0] other_width,
   input  wire logic        [COORD_BITS-2:0] other_height,
   input  wire logic        [COORD_BITS-2:0] other_radius,
   output logic                              valid_out,
   output cop_pkg::ctl_type                  ctl_out,
   output logic             [COORD_BITS+1:0] gap_x_out,
   output logic             [COORD_BITS+1:0] gap_y_out,
   output logic             [COORD_BITS-1:0] reach_out
);

   localparam int unsigned W = COORD_BITS;

   // Offset beyond the clamped extent, in doubled units.
   function automatic logic [W+1:0] clamp_gap(input logic signed [W+2:0] d2,
                                              input logic signed [W+2:0] ext);
      logic signed [W+2:0] t;
      begin
         if (d2 > ext) begin
            t = d2 - ext;
         end else if (d2 < -ext) begin
            t = -ext - d2;
         end else begin
            t = '0;
         end
         return t[W+1:0];
      end
   endfunction

   logic signed [W+2:0] sx_e, sy_e, ox_e, oy_e;
   logic signed [W+2:0] sw_e, sh_e, ow_e, oh_e;
   logic signed [W+2:0] cx, cy, rx, ry, rw, rh;
   logic        [W-2:0] cr;
   logic signed [W+2:0] dx, dy, d2x, d2y;
   logic signed [W+2:0] ax, ay, mx, my;
   logic        [W+1:0] cc_gap_x, cc_gap_y, cr_gap_x, cr_gap_y;
   logic        [W-1:0] rsum;
   logic                hit_x, hit_y;
   cop_pkg::pair_mode_type mode;

   logic                valid_ff, valid_in_d;
   cop_pkg::ctl_type    ctl_ff, ctl_in;
   logic        [W+1:0] gap_x_ff, gap_x_in, gap_y_ff, gap_y_in;
   logic        [W-1:0] reach_ff, reach_in;

   assign valid_in_d = valid_in;

   always_comb begin
      sx_e = {{3{self_x[W-1]}}, self_x};
      sy_e = {{3{self_y[W-1]}}, self_y};
      ox_e = {{3{other_x[W-1]}}, other_x};
      oy_e = {{3{other_y[W-1]}}, other_y};
      sw_e = {4'b0000, self_width};
      sh_e = {4'b0000, self_height};
      ow_e = {4'b0000, other_width};
      oh_e = {4'b0000, other_height};

      if (self_kind == other_kind) begin
         mode = (self_kind == cop_pkg::KIND_CIRCLE) ? cop_pkg::MODE_CIRC_CIRC
                                                    : cop_pkg::MODE_RECT_RECT;
      end else begin
         mode = cop_pkg::MODE_CIRC_RECT;
      end

      // Mixed pair: pick which collider is the circle.
      if (self_kind == cop_pkg::KIND_CIRCLE) begin
         cx = sx_e; cy = sy_e; cr = self_radius;
         rx = ox_e; ry = oy_e; rw = ow_e; rh = oh_e;
      end else begin
         cx = ox_e; cy = oy_e; cr = other_radius;
         rx = sx_e; ry = sy_e; rw = sw_e; rh = sh_e;
      end

      dx  = cx - rx;
      dy  = cy - ry;
      d2x = {dx[W+1:0], 1'b0};
      d2y = {dy[W+1:0], 1'b0};
      cr_gap_x = clamp_gap(d2x, rw);
      cr_gap_y = clamp_gap(d2y, rh);

      // Circle pair: doubled centre distance.
      ax = sx_e - ox_e;
      ay = sy_e - oy_e;
      mx = (ax < 0) ? -ax : ax;
      my = (ay < 0) ? -ay : ay;
      cc_gap_x = {mx[W:0], 1'b0};
      cc_gap_y = {my[W:0], 1'b0};
      rsum = {1'b0, self_radius} + {1'b0, other_radius};

      hit_x = (sx_e + sw_e >= ox_e) && (ox_e + ow_e >= sx_e);
      hit_y = (sy_e + sh_e >= oy_e) && (oy_e + oh_e >= sy_e);

      if (mode == cop_pkg::MODE_CIRC_CIRC) begin
         gap_x_in = cc_gap_x;
         gap_y_in = cc_gap_y;
         reach_in = rsum;
      end else begin
         gap_x_in = cr_gap_x;
         gap_y_in = cr_gap_y;
         reach_in = {cr, 1'b0};
      end

      ctl_in.last     = last_in;
      ctl_in.skip     = skip_in;
      ctl_in.mode     = mode;
      ctl_in.rect_hit = hit_x && hit_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in_d;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff   <= ctl_in;
         gap_x_ff <= gap_x_in;
         gap_y_ff <= gap_y_in;
         reach_ff <= reach_in;
      end
   end

   assign valid_out = valid_ff;
   assign ctl_out   = ctl_ff;
   assign gap_x_out = gap_x_ff;
   assign gap_y_out = gap_y_ff;
   assign reach_out = reach_ff;

endmodule
`default_nettype wire

>>> rtl/core/cop_square.sv
// Square stage: squares of the two gaps and of the reach, registered.
`default_nettype none
module cop_square #(
   parameter int unsigned COORD_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    en,
   input  wire logic                    valid_in,
   input  wire cop_pkg::ctl_type        ctl_in,
   input  wire logic [COORD_BITS+1:0]   gap_x,
   input  wire logic [COORD_BITS+1:0]   gap_y,
   input  wire logic [COORD_BITS-1:0]   reach,
   output logic                         valid_out,
   output cop_pkg::ctl_type             ctl_out,
   output logic [2*COORD_BITS+3:0]      sq_x_out,
   output logic [2*COORD_BITS+3:0]      sq_y_out,
   output logic [2*COORD_BITS-1:0]      sq_r_out
);

   localparam int unsigned W = COORD_BITS;

   logic             valid_ff;
   cop_pkg::ctl_type ctl_ff;
   logic [2*W+3:0]   sq_x_ff, sq_x_in, sq_y_ff, sq_y_in;
   logic [2*W-1:0]   sq_r_ff, sq_r_in;

   assign sq_x_in = gap_x * gap_x;
   assign sq_y_in = gap_y * gap_y;
   assign sq_r_in = reach * reach;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_ff  <= ctl_in;
         sq_x_ff <= sq_x_in;
         sq_y_ff <= sq_y_in;
         sq_r_ff <= sq_r_in;
      end
   end

   assign valid_out = valid_ff;
   assign ctl_out   = ctl_ff;
   assign sq_x_out  = sq_x_ff;
   assign sq_y_out  = sq_y_ff;
   assign sq_r_out  = sq_r_ff;

endmodule
`default_nettype wire
